// File: src/positional_list_engine_core_macros.svh
// Assertion macros for the positional list engine.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PLE_ASSERT_ALWAYS(lbl, cond, msg)
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/ple_pkg.sv
// Shared types and codes for the positional list engine.
// No dependencies; used by ple_cell, ple_find and the top level.
package ple_pkg;

  localparam int PLE_DEPTH = 32;
  // Cell index field sized for the largest supported depth (1024).
  localparam int IDX_W = 10;

  localparam logic [2:0] REQ_FILL   = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_FIND   = 3'd3;
  localparam logic [2:0] REQ_AMEND  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_FILL,
    OP_INS,
    OP_DEL,
    OP_WR
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
  } cell_cmd_t;

endpackage

// File: src/ple_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares for find.
// Depends on ple_pkg.
module ple_cell import ple_pkg::*; #(
  parameter int DEPTH = PLE_DEPTH,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_cmd_t         cmd,
  input  logic [31:0]       wr_val,
  input  logic [31:0]       left_entry,
  input  logic [31:0]       right_entry,
  input  logic [CW-1:0]     count,
  output logic [31:0]       entry,
  output logic              hit
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CW:0]      MY_IDX_C = (CW + 1)'(IDX);

  logic [31:0] entry_r, entry_nxt;
  logic        hit_r;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      OP_FILL: entry_nxt = 32'(IDX + 1);
      OP_INS: begin
        if (MY_IDX > cmd.idx) entry_nxt = left_entry;
        else if (MY_IDX == cmd.idx) entry_nxt = wr_val;
      end
      OP_DEL: begin
        if (MY_IDX >= cmd.idx) entry_nxt = right_entry;
      end
      OP_WR: begin
        if (MY_IDX == cmd.idx) entry_nxt = wr_val;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      // live slot whose content matches the search word
      hit_r <= (entry_r == wr_val) && ({1'b0, count} > MY_IDX_C);
    end
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

// File: src/ple_find.sv
// First-hit encoder over the cell match flags, registered.
// Depends on ple_pkg.
module ple_find import ple_pkg::*; #(
  parameter int DEPTH = PLE_DEPTH,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DEPTH-1:0] hits,
  output logic             any_hit,
  output logic [CW-1:0]    first_pos
);

  logic          any_r, any_nxt;
  logic [CW-1:0] pos_r, pos_nxt;

  always_comb begin
    any_nxt = |hits;
    pos_nxt = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (hits[j]) pos_nxt = CW'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
      pos_r <= '0;
    end else if (en) begin
      any_r <= any_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign any_hit   = any_r;
  assign first_pos = pos_r;

endmodule

// File: src/positional_list_engine_core.sv
// Positional list engine: one request word in, one result word out.
// One request at a time: a word is accepted only in S_IDLE, then runs S_EXEC,
// S_SRCH for find, and S_RESP, which waits for the output register to be free.
// A finished result sits in the output register while the next word is accepted.
// Reset (rst_n low, synchronous) empties the list; entry contents are undefined
// until written by fill or insert.
module positional_list_engine_core import ple_pkg::*; #(
  parameter int DEPTH = PLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_position,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_fill_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_found_position,
  output logic [5:0]  out_list_length
);

`include "positional_list_engine_core_macros.svh"

  localparam int CW   = $clog2(DEPTH + 1);
  // compare width: room for position, count and count+1
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,   // decide, update cells, capture match flags
    S_SRCH,   // find only: encode first hit
    S_RESP    // load output register once it is free
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    status_r, status_nxt;

  // latched request word
  logic [2:0]  req_r;
  logic [5:0]  pos_r;
  logic [31:0] val_r;
  logic [5:0]  fcnt_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [5:0]  out_found_r, out_found_nxt;
  logic [5:0]  out_len_r, out_len_nxt;

  cell_cmd_t   cmd;
  logic        in_acc;
  logic        out_free;

  logic [31:0]      entry_q [DEPTH];
  logic [DEPTH-1:0] hit_q;
  logic             any_hit;
  logic [CW-1:0]    first_pos;

  logic [CMPW-1:0] pos_ext, pos_eff, cnt_ext, fcnt_ext, depth_c;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign pos_ext  = CMPW'(pos_r);
  assign pos_eff  = (pos_r == 6'd0) ? CMPW'(1) : pos_ext;   // position 0 acts as 1
  assign cnt_ext  = CMPW'(count_r);
  assign fcnt_ext = CMPW'(fcnt_r);
  assign depth_c  = CMPW'(DEPTH);

  // Request decode: runs in S_EXEC against the latched word and current count.
  always_comb begin
    cmd.op     = OP_HOLD;
    cmd.idx    = IDX_W'(pos_eff - CMPW'(1));
    count_nxt  = count_r;
    status_nxt = status_r;
    if (state_r == S_EXEC) begin
      status_nxt = ST_OK;
      case (req_r)
        REQ_FILL: begin
          if (fcnt_ext > depth_c) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op    = OP_FILL;
            count_nxt = CW'(fcnt_ext);
          end
        end
        REQ_INSERT: begin
          // bad position is checked before full
          if (pos_eff > cnt_ext + CMPW'(1)) begin
            status_nxt = ST_BADPOS;
          end else if (cnt_ext >= depth_c) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op    = OP_INS;
            count_nxt = CW'(cnt_ext + CMPW'(1));
          end
        end
        REQ_DELETE: begin
          if (pos_eff > cnt_ext) begin
            status_nxt = ST_BADPOS;
          end else begin
            cmd.op    = OP_DEL;
            count_nxt = CW'(cnt_ext - CMPW'(1));
          end
        end
        REQ_FIND: status_nxt = ST_OK;   // settled after the encoder
        REQ_AMEND: begin
          // amend at position zero is a silent no-op
          if (pos_r == 6'd0) begin
            status_nxt = ST_OK;
          end else if (pos_ext > cnt_ext) begin
            status_nxt = ST_BADPOS;
          end else begin
            cmd.op  = OP_WR;
            cmd.idx = IDX_W'(pos_ext - CMPW'(1));
          end
        end
        default: status_nxt = ST_BADPOS;
      endcase
    end
  end

  // Sequencer and output register
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: state_nxt = (req_r == REQ_FIND) ? S_SRCH : S_RESP;
      S_SRCH: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_len_nxt   = 6'(count_r);
          if (req_r == REQ_FIND) begin
            out_status_nxt = any_hit ? ST_OK : ST_NOTFOUND;
            out_found_nxt  = any_hit ? 6'(first_pos) : 6'd0;
          end else begin
            out_status_nxt = status_r;
            out_found_nxt  = 6'd0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      req_r  <= in_req_type;
      pos_r  <= in_position;
      val_r  <= in_value;
      fcnt_r <= in_fill_count;
    end
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
  end

  // Row of list cells, each linked to its two neighbors.
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (j == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_q[j-1];
    end
    if (j == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_q[j+1];
    end
    ple_cell #(
      .DEPTH (DEPTH),
      .IDX   (j)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .wr_val      (val_r),
      .left_entry  (left_w),
      .right_entry (right_w),
      .count       (count_r),
      .entry       (entry_q[j]),
      .hit         (hit_q[j])
    );
  end

  ple_find #(
    .DEPTH (DEPTH)
  ) u_find (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (state_r == S_SRCH),
    .hits      (hit_q),
    .any_hit   (any_hit),
    .first_pos (first_pos)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_len_r;

  `PLE_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "list count above depth")
  `PLE_ASSERT_NEXT(a_accept_exec, in_acc, state_r == S_EXEC, "accepted word not executed")
  `PLE_ASSERT_NEXT(a_count_only_exec, state_r != S_EXEC, $stable(count_r), "count moved outside exec")
  `PLE_ASSERT_NEXT(a_resp_loads, (state_r == S_RESP) && out_free, out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule

// File: tb/tb_top.sv
// Self-checking bench for positional_list_engine_core: list requests in, one result word out.
// Needs ple_pkg and the core RTL. The expected results come from an in-bench list predictor.
module tb_top;
  import ple_pkg::*;

  // Run shape
  localparam int N_RANDOM    = 925;     // random requests after the directed opening
  localparam int N_CALM      = 80;      // tail of the run with no idling on either side
  localparam int HOLD_AT     = 300;     // accepted words before the long receiver hold
  localparam int HOLD_CYCLES = 250;     // length of that hold
  localparam int DRAIN       = 20;      // settle time once nothing is pending
  localparam int CYCLE_LIMIT = 200000;  // hard stop, well above the slowest legal run

  // One request word and one result word, at the port widths.
  typedef struct packed {
    logic [2:0]  req;
    logic [5:0]  pos;
    logic [31:0] val;
    logic [5:0]  fcnt;
  } list_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] found;
    logic [5:0] length;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [5:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic [5:0]  in_fill_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_found_position;
  logic [5:0]  out_list_length;

  positional_list_engine_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_position        (in_position),
    .in_value           (in_value),
    .in_fill_count      (in_fill_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the list as the engine should hold it.
  logic [31:0]  list_vals [PLE_DEPTH];
  int           list_len = 0;

  list_req_t    pending_reqs[$];     // words waiting for the driver
  list_result_t expected_results[$]; // results owed by the engine, oldest first

  int n_errors   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_cycles   = 0;
  int status_seen [4] = '{default: 0};
  int gap_left   = 0;   // sender idle cycles still to insert
  int stall_left = 0;   // receiver stall cycles still to insert
  int hold_left  = 0;   // long receiver hold, counted down in the stall process
  bit hold_done  = 1'b0;
  bit calm       = 1'b0; // set for the tail: no idling at all

  task automatic note_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  // Apply one request to the predicted list and return the result it must produce.
  // Position 0 means 1 for insert/delete; amend at 0 is a no-op that reports ok.
  // Insert checks the position before the full condition.
  function automatic list_result_t apply_request(input list_req_t r);
    list_result_t res;
    int p;
    int i;
    res = '0;
    res.status = ST_OK;
    p = (r.pos == 0) ? 1 : int'(r.pos);
    case (r.req)
      REQ_FILL: begin
        if (r.fcnt > PLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = 0; i < r.fcnt; i++) list_vals[i] = 32'(i + 1);
          list_len = r.fcnt;
        end
      end
      REQ_INSERT: begin
        if (p > list_len + 1) begin
          res.status = ST_BADPOS;
        end else if (list_len >= PLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i >= p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p-1] = r.val;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (p > list_len) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = p; i < list_len; i++) list_vals[i-1] = list_vals[i];
          list_len--;
        end
      end
      REQ_FIND: begin
        // first match wins
        res.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (res.status == ST_NOTFOUND && list_vals[i] == r.val) begin
            res.status = ST_OK;
            res.found  = 6'(i + 1);
          end
        end
      end
      REQ_AMEND: begin
        if (r.pos != 0) begin
          if (r.pos > list_len) res.status = ST_BADPOS;
          else list_vals[r.pos-1] = r.val;
        end
      end
      default: res.status = ST_BADPOS;  // unused request codes
    endcase
    res.length = 6'(list_len);
    return res;
  endfunction

  function automatic void queue_request(input logic [2:0] rq, input logic [5:0] ps,
                                        input logic [31:0] vl, input logic [5:0] fc);
    list_req_t r;
    r.req  = rq;
    r.pos  = ps;
    r.val  = vl;
    r.fcnt = fc;
    pending_reqs.push_back(r);
  endfunction

  // Random request shaped by the current predicted length, so that most
  // positions land in or just past the live range. The predicted length lags
  // the queue by a couple of words, which only adds variety.
  function automatic list_req_t make_random_request();
    list_req_t r;
    int sel;
    int cnt;
    cnt    = list_len;
    sel    = $urandom_range(0, 99);
    r.req  = 3'($urandom_range(0, 7));
    r.pos  = 6'($urandom);
    r.fcnt = 6'($urandom);
    // values: small ones collide with fill contents, full-width ones hit every bit
    case ($urandom_range(0, 3))
      0, 1:    r.val = $urandom;
      2:       r.val = 32'($urandom_range(0, 40));
      default: r.val = 32'hFFFF_FFFF;
    endcase
    if (sel < 8) begin
      r.req  = REQ_FILL;
      r.fcnt = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                           : 6'($urandom_range(0, 32));
    end else if (sel < 40) begin
      r.req = REQ_INSERT;
      r.pos = 6'($urandom_range(0, cnt + 1));
    end else if (sel < 60) begin
      r.req = REQ_DELETE;
      r.pos = 6'($urandom_range(0, cnt));
    end else if (sel < 80) begin
      r.req = REQ_FIND;
      if (cnt > 0 && $urandom_range(0, 1) == 1) r.val = list_vals[$urandom_range(0, cnt - 1)];
    end else if (sel < 94) begin
      r.req = REQ_AMEND;
      r.pos = 6'($urandom_range(0, cnt));
    end
    // else: noise word, any code and any position as drawn above
    return r;
  endfunction

  // Stimulus: reset, directed corner cases, then random words fed just ahead of the driver.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: find, delete, amend at 0 and 1
    queue_request(REQ_FIND,   6'd0,  32'd5,         6'd0);
    queue_request(REQ_DELETE, 6'd0,  32'd0,         6'd0);
    queue_request(REQ_AMEND,  6'd0,  32'hDEAD_BEEF, 6'd0);
    queue_request(REQ_AMEND,  6'd1,  32'hDEAD_BEEF, 6'd0);
    // insert at 0 acts as 1; then a position far past the end; then append
    queue_request(REQ_INSERT, 6'd0,  32'h8000_0000, 6'd0);
    queue_request(REQ_INSERT, 6'd63, 32'd7,         6'd0);
    queue_request(REQ_INSERT, 6'd2,  32'h7FFF_FFFF, 6'd0);
    queue_request(REQ_FIND,   6'd0,  32'h8000_0000, 6'd0);
    // unused request codes, with every other field at its top
    queue_request(3'd5,       6'd63, 32'hFFFF_FFFF, 6'd63);
    queue_request(3'd6,       6'd63, 32'hFFFF_FFFF, 6'd63);
    queue_request(3'd7,       6'd63, 32'hFFFF_FFFF, 6'd63);
    // fill too large, fill empty, fill to the top
    queue_request(REQ_FILL,   6'd0,  32'd0,         6'd63);
    queue_request(REQ_FILL,   6'd0,  32'd0,         6'd33);
    queue_request(REQ_FILL,   6'd0,  32'd0,         6'd0);
    queue_request(REQ_FILL,   6'd0,  32'd0,         6'd32);
    // full list: valid positions report full, a position past the end reports bad
    queue_request(REQ_INSERT, 6'd33, 32'd1,         6'd0);
    queue_request(REQ_INSERT, 6'd34, 32'd1,         6'd0);
    queue_request(REQ_INSERT, 6'd0,  32'd1,         6'd0);
    queue_request(REQ_FIND,   6'd0,  32'd32,        6'd0);
    queue_request(REQ_AMEND,  6'd32, 32'hFFFF_FFFF, 6'd0);
    queue_request(REQ_FIND,   6'd0,  32'hFFFF_FFFF, 6'd0);
    // delete past the end, at 0, at the last slot; amend past the end
    queue_request(REQ_DELETE, 6'd33, 32'd0,         6'd0);
    queue_request(REQ_DELETE, 6'd0,  32'd0,         6'd0);
    queue_request(REQ_DELETE, 6'd31, 32'd0,         6'd0);
    queue_request(REQ_AMEND,  6'd31, 32'd9,         6'd0);

    for (int k = 0; k < N_RANDOM; k++) begin
      while (pending_reqs.size() >= 2) @(posedge clk);
      if (k == N_RANDOM - N_CALM) calm = 1'b1;
      pending_reqs.push_back(make_random_request());
    end

    // wait for the last word to go in and every owed result to come back
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("covered %0d requests, %0d results checked", n_accepted, n_checked);
    $display("status mix: ok %0d, bad position %0d, list full %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_FULL],
             status_seen[ST_NOTFOUND]);
    if (n_errors == 0) begin
      $display("[positional_list_engine_core] OK");
    end else begin
      $display("[positional_list_engine_core] ERROR");
    end
    $finish;
  end

  // Driver: a word is taken at an edge with valid high and stall low; the predictor
  // runs right there. A stalled word is held untouched. After a word goes out the
  // sender sometimes idles for a burst, so gaps land on every phase of the engine.
  always @(posedge clk) begin : drive_words
    list_req_t nxt;
    list_result_t owed;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.req  = in_req_type;
        nxt.pos  = in_position;
        nxt.val  = in_value;
        nxt.fcnt = in_fill_count;
        owed = apply_request(nxt);
        expected_results.push_back(owed);
        status_seen[owed.status]++;
        n_accepted++;
      end
      if (in_valid && in_stall) begin
        // hold the word as is
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        in_req_type   <= nxt.req;
        in_position   <= nxt.pos;
        in_value      <= nxt.val;
        in_fill_count <= nxt.fcnt;
        in_valid      <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold once enough words are in,
  // so the output register stays full and the engine must stall its input.
  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: every accepted result word is checked against the oldest owed one.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d found %0d length %0d",
                                out_status, out_found_position, out_list_length));
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (out_status !== want.status)
          note_mismatch($sformatf("result %0d status %0d, want %0d",
                                  n_checked, out_status, want.status));
        if (out_found_position !== want.found)
          note_mismatch($sformatf("result %0d found_position %0d, want %0d",
                                  n_checked, out_found_position, want.found));
        if (out_list_length !== want.length)
          note_mismatch($sformatf("result %0d list_length %0d, want %0d",
                                  n_checked, out_list_length, want.length));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words in, %0d checked",
               n_cycles, n_accepted, n_checked);
      $display("[positional_list_engine_core] ERROR");
      $finish;
    end
  end

endmodule

// File: positional_list_engine_core.f
+incdir+src
src/ple_pkg.sv
src/ple_cell.sv
src/ple_find.sv
src/positional_list_engine_core.sv
tb/tb_top.sv
